>>> rtl/io_port_range_allocator_unit_defines.svh
// Assertion macros for the I/O port range allocator.
// Included by the top level; depends on nothing else.
`ifndef IO_PORT_RANGE_ALLOCATOR_UNIT_DEFINES_SVH
`define IO_PORT_RANGE_ALLOCATOR_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define IPRA_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define IPRA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/ipra_pkg.sv
// Shared types and constants for the I/O port range allocator.
// Used by the controller, the datapath and the top level.
package ipra_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int PORT_SPACE_DEF    = 65536;

    localparam logic [15:0] SEARCH_BASE_RST  = 16'h0400;
    localparam logic [16:0] SEARCH_LIMIT_RST = 17'h01000;
    localparam logic [16:0] VGA_A_LO = 17'h002b0;
    localparam logic [16:0] VGA_A_HI = 17'h002e0;
    localparam logic [16:0] VGA_B_LO = 17'h003c0;
    localparam logic [16:0] VGA_B_HI = 17'h003db;

    localparam logic [1:0] CMD_FIXED  = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;
    localparam logic [1:0] CMD_CHECK  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CLASH    = 3'd1;
    localparam logic [2:0] ST_NOREGION = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic CFG_SEARCH_BASE  = 1'b0;
    localparam logic CFG_SEARCH_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] port;
        logic [16:0] size;
        logic [12:0] align;
        logic [16:0] range_end;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_port;
        logic        range_unused;
        logic        access_permitted;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture request, reset walk index
        logic align_init; // start aligning a value
        logic align_src;  // 0 search base, 1 stop of current entry
        logic align_step; // one restoring-division step
        logic align_done; // write aligned value to candidate
        logic rd;         // issue table read at walk index
        logic eval;       // evaluate registered entry
        logic shift_step; // one read or one write of a move of insert or remove
        logic write_new;  // write new entry at insert position
        logic finish;     // form the response
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic walk_end;   // walk index reached entry count, or fixed range out of space
        logic stop_walk;  // evaluation ends the walk
        logic realign;    // evaluation needs the candidate realigned
        logic align_last; // last division step
        logic shift_end;  // shifting finished
        logic needs_ins;  // command inserts an entry
        logic needs_del;  // command removes an entry
        logic is_search;  // command is a search
    } dp_sts_t;

endpackage

>>> rtl/ipra_ctrl.sv
// Command sequencer for the I/O port range allocator.
// Depends on ipra_pkg for the command and status structs.
module ipra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ipra_pkg::dp_cmd_t  cmd,
    input  ipra_pkg::dp_sts_t  sts
);
    import ipra_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ALGI  = 9'b000000010,
        S_ALGS  = 9'b000000100,
        S_RD    = 9'b000001000,
        S_EVAL  = 9'b000010000,
        S_DEC   = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_ALGI;
                end
            end
            S_ALGI:
            begin
                cmd.align_init = 1'b1;
                cmd.align_src = 1'b0;
                state_next = sts.is_search ? S_ALGS : S_RD;
            end
            S_ALGS:
            begin
                cmd.align_step = 1'b1;
                if (sts.align_last)
                begin
                    cmd.align_done = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.walk_end)
                    state_next = S_DEC;
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.stop_walk)
                    state_next = S_DEC;
                else if (sts.realign)
                begin
                    cmd.align_init = 1'b1;
                    cmd.align_src = 1'b1;
                    state_next = S_ALGS;
                end
                else
                    state_next = S_RD;
            end
            S_DEC:
            begin
                state_next = (sts.needs_ins || sts.needs_del) ? S_SHIFT : S_FIN;
            end
            S_SHIFT:
            begin
                if (sts.shift_end)
                begin
                    cmd.write_new = sts.needs_ins;
                    state_next = S_FIN;
                end
                else
                    cmd.shift_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/ipra_dp.sv
// Datapath of the I/O port range allocator: range table memory, walk,
// alignment divider and shifting. Depends on ipra_pkg.
module ipra_dp #(
    parameter int TABLE_ENTRIES = ipra_pkg::TABLE_ENTRIES_DEF,
    parameter int PORT_SPACE    = ipra_pkg::PORT_SPACE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ipra_pkg::req_t     req,
    input  logic               cfg_we,
    input  logic               cfg_sel,
    input  logic [16:0]        cfg_data,
    input  ipra_pkg::dp_cmd_t  cmd,
    output ipra_pkg::dp_sts_t  sts,
    output ipra_pkg::rsp_t     rsp,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] count
);
    import ipra_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [17:0] SPACE = 18'(PORT_SPACE);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    // Range table, one word per entry: start and exclusive stop.
    logic [32:0] mem [TABLE_ENTRIES];
    logic [32:0] rd_data_reg;

    logic [15:0] base_reg;
    logic [16:0] limit_reg;
    logic [CW-1:0] count_reg;
    req_t        req_reg;
    logic [CW-1:0] idx_reg;
    logic [17:0] cand_reg;
    logic        clash_reg;
    logic        found_reg;
    logic        unused_reg;

    // Alignment divider: the dividend is biased by align - 1 when it is loaded,
    // so the restoring division yields ceil(x / a); the result is q * a.
    logic [17:0] dvd_reg;
    logic [16:0] quo_reg;
    logic [13:0] rem_reg;
    logic [4:0]  abit_reg;
    logic        azero_reg;

    // Shift engine.
    logic [CW-1:0] sh_reg;
    logic          sh_phase_reg;
    logic [32:0]   sh_data_reg;

    assign count = count_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= SEARCH_BASE_RST;
            limit_reg <= SEARCH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_sel == CFG_SEARCH_BASE)
                base_reg <= cfg_data[15:0];
            else
                limit_reg <= cfg_data;
        end
    end

    // Current entry fields.
    logic [17:0] e_start, e_stop, cend, pend;
    assign e_start = {2'b00, rd_data_reg[32:17]};
    assign e_stop  = {1'b0, rd_data_reg[16:0]};
    assign cend    = cand_reg + {1'b0, req_reg.size};
    assign pend    = {2'b00, req_reg.port} + {1'b0, req_reg.size};

    logic is_fixed, is_search, is_free, is_check;
    assign is_fixed  = (req_reg.command == CMD_FIXED);
    assign is_search = (req_reg.command == CMD_SEARCH);
    assign is_free   = (req_reg.command == CMD_FREE);
    assign is_check  = (req_reg.command == CMD_CHECK);

    logic fixed_oob;
    assign fixed_oob = ({2'b00, req_reg.port} >= SPACE) || (pend > SPACE);

    // Evaluation of one entry for each command.
    logic stop_w, realign_w, clash_w, found_w, used_w;
    always_comb
    begin
        stop_w = 1'b0;
        realign_w = 1'b0;
        clash_w = 1'b0;
        found_w = 1'b0;
        used_w = 1'b0;
        case (req_reg.command)
            CMD_FIXED:
            begin
                if (e_stop > {2'b00, req_reg.port})
                begin
                    stop_w = 1'b1;
                    clash_w = (e_start < pend);
                end
            end
            CMD_SEARCH:
            begin
                if (e_stop > cand_reg)
                begin
                    if (e_start >= cend)
                        stop_w = 1'b1;
                    else
                        realign_w = 1'b1;
                end
            end
            CMD_FREE:
            begin
                if (e_start == {2'b00, req_reg.port})
                begin
                    found_w = 1'b1;
                    stop_w = 1'b1;
                end
                else if (e_start > {2'b00, req_reg.port})
                    stop_w = 1'b1;
            end
            default:
            begin
                used_w = ((req_reg.port >= rd_data_reg[32:17]) &&
                          ({1'b0, req_reg.port} < rd_data_reg[16:0])) ||
                         ((req_reg.port <= rd_data_reg[32:17]) &&
                          (req_reg.range_end > {1'b0, rd_data_reg[32:17]}));
                stop_w = used_w;
            end
        endcase
    end

    // Final decision for insert or remove.
    logic [17:0] lim_eff;
    logic        search_fail;
    logic        ins_ok, del_ok;
    assign lim_eff = ({1'b0, limit_reg} > SPACE) ? SPACE : {1'b0, limit_reg};
    assign search_fail = (cand_reg >= SPACE) || (cend > lim_eff);
    assign ins_ok = (count_reg < FULL) &&
                    ((is_fixed && !fixed_oob && !clash_reg) ||
                     (is_search && !search_fail));
    assign del_ok = is_free && found_reg;

    assign sts.walk_end   = (idx_reg >= count_reg) || (is_fixed && fixed_oob);
    assign sts.stop_walk  = stop_w;
    assign sts.realign    = realign_w;
    assign sts.align_last = azero_reg || (abit_reg == 5'd0);
    assign sts.needs_ins  = ins_ok;
    assign sts.needs_del  = del_ok;
    assign sts.is_search  = is_search;
    assign sts.shift_end  = ins_ok ? (sh_reg == idx_reg && !sh_phase_reg)
                                   : (sh_reg + CW'(1) >= count_reg && !sh_phase_reg);

    // One division step on the next dividend bit.
    logic [13:0] rem_sh;
    logic [13:0] adiv;
    logic [17:0] align_res;
    logic [17:0] align_bias;
    assign adiv = {1'b0, req_reg.align};
    assign align_bias = (req_reg.align == '0) ? 18'd0 : {5'b0, req_reg.align} - 18'd1;
    assign rem_sh = {rem_reg[12:0], dvd_reg[abit_reg]};
    logic [16:0] quo_n;
    logic [13:0] rem_n;
    always_comb
    begin
        if (rem_sh >= adiv)
        begin
            rem_n = rem_sh - adiv;
            quo_n = {quo_reg[15:0], 1'b1};
        end
        else
        begin
            rem_n = rem_sh;
            quo_n = {quo_reg[15:0], 1'b0};
        end
    end
    // Quotient times align fits 30 bits; result kept to 18.
    logic [29:0] prod;
    assign prod = {13'b0, quo_n} * {17'b0, req_reg.align};
    assign align_res = azero_reg ? dvd_reg : prod[17:0];

    logic [IW-1:0] idx_a, sh_a;
    assign idx_a = idx_reg[IW-1:0];
    assign sh_a  = sh_reg[IW-1:0];

    // Sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            sh_phase_reg <= 1'b0;
            sh_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                sh_phase_reg <= 1'b0;
            end
            if (cmd.eval && !stop_w && !realign_w)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.align_done && !cmd.load && idx_reg != '0)
                idx_reg <= idx_reg;
            if (cmd.eval && realign_w)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.finish)
            begin
                if (ins_ok)
                    count_reg <= count_reg + CW'(1);
                else if (del_ok)
                    count_reg <= count_reg - CW'(1);
            end
            // Shift pointer: insert moves down from the count, remove moves up.
            if (!cmd.shift_step && !cmd.write_new && !cmd.finish)
                sh_reg <= ins_ok ? count_reg : idx_reg;
            if (cmd.shift_step)
            begin
                if (!sh_phase_reg)
                    sh_phase_reg <= 1'b1;
                else
                begin
                    sh_phase_reg <= 1'b0;
                    sh_reg <= ins_ok ? sh_reg - CW'(1) : sh_reg + CW'(1);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            clash_reg <= 1'b0;
            found_reg <= 1'b0;
            unused_reg <= 1'b1;
            cand_reg <= '0;
        end
        if (cmd.eval)
        begin
            if (clash_w)
                clash_reg <= 1'b1;
            if (found_w)
                found_reg <= 1'b1;
            if (used_w)
                unused_reg <= 1'b0;
        end
        if (cmd.align_init)
        begin
            dvd_reg <= (cmd.align_src ? e_stop : {2'b00, base_reg}) + align_bias;
            azero_reg <= (req_reg.align == '0);
            abit_reg <= 5'd17;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.align_step)
        begin
            if (!azero_reg)
            begin
                quo_reg <= quo_n;
                rem_reg <= rem_n;
                abit_reg <= abit_reg - 5'd1;
            end
        end
        if (cmd.align_done)
            cand_reg <= align_res;
    end

    // Table read at the walk index, or at the shift source.
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            rd_data_reg <= mem[idx_a];
        else if (cmd.shift_step && !sh_phase_reg)
            sh_data_reg <= ins_ok ? mem[sh_a - IW'(1)] : mem[sh_a + IW'(1)];
    end

    // Table write for shifting and the new entry.
    logic [17:0] new_start, new_stop;
    assign new_start = is_search ? cand_reg : {2'b00, req_reg.port};
    assign new_stop  = is_search ? cend : pend;
    always_ff @(posedge clk)
    begin
        if (cmd.shift_step && sh_phase_reg)
            mem[sh_a] <= sh_data_reg;
        else if (cmd.write_new)
            mem[idx_a] <= {new_start[15:0], new_stop[16:0]};
    end

    // Response word.
    logic vga;
    assign vga = ({1'b0, req_reg.port} >= VGA_A_LO && req_reg.range_end <= VGA_A_HI) ||
                 ({1'b0, req_reg.port} >= VGA_B_LO && req_reg.range_end <= VGA_B_HI);
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp.range_unused <= is_check & unused_reg;
            rsp.access_permitted <= is_check & (unused_reg | vga);
            rsp.result_port <= '0;
            if (is_fixed)
            begin
                if (fixed_oob || clash_reg)
                    rsp.status <= ST_CLASH;
                else if (!ins_ok)
                    rsp.status <= ST_FULL;
                else
                begin
                    rsp.status <= ST_OK;
                    rsp.result_port <= req_reg.port;
                end
            end
            else if (is_search)
            begin
                if (search_fail)
                    rsp.status <= ST_NOREGION;
                else if (!ins_ok)
                    rsp.status <= ST_FULL;
                else
                begin
                    rsp.status <= ST_OK;
                    rsp.result_port <= cand_reg[15:0];
                end
            end
            else if (is_free)
            begin
                rsp.status <= del_ok ? ST_OK : ST_NOTFOUND;
                if (del_ok)
                    rsp.result_port <= req_reg.port;
            end
            else
                rsp.status <= ST_OK;
        end
    end

endmodule

>>> rtl/io_port_range_allocator_unit.sv
// I/O port range allocator: a sorted table of allocated port ranges walked one
// entry at a time, each entry read from the table memory's registered read port
// and then evaluated. A fixed allocate, free or check walks until an entry ends
// the walk or all entries are covered. A search first aligns the search base in
// the bit-serial alignment divider, which does not divide when align is zero,
// and realigns past each entry that overlaps the candidate; an insert or remove
// then moves entries one at a time, each move a read and then a write. Results
// wait in an output register; the next word is accepted only once the result
// is taken.
module io_port_range_allocator_unit #(
    parameter int TABLE_ENTRIES = ipra_pkg::TABLE_ENTRIES_DEF,
    parameter int PORT_SPACE    = ipra_pkg::PORT_SPACE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ipra_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ipra_pkg::rsp_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [16:0]    cfg_data
);
    import ipra_pkg::*;
    `include "io_port_range_allocator_unit_defines.svh"

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic [$clog2(TABLE_ENTRIES+1)-1:0] count;

    assign cfg_ready = 1'b1;

    ipra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ipra_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_SPACE    (PORT_SPACE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (in_data),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_sel  (cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (out_data),
        .count    (count)
    );

    // The entry count never passes the table size.
    `IPRA_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count <= TABLE_ENTRIES)
    // A new word is never taken while a result is pending.
    `IPRA_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready)
    // A finished response is presented next cycle.
    `IPRA_ASSERT_NEXT(a_fin, clk, rst_n, cmd.finish, out_valid)

endmodule
